// ===== hdl/arp_request_reply_tracker_core_macros.svh =====
// ----------------------------------------------------------------------------
// ARP tracker assertion macros
// Shorthand for clocked implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARP_REQUEST_REPLY_TRACKER_CORE_MACROS_SVH
`define ARP_REQUEST_REPLY_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define ARPT_AST_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ARPT_AST_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/arpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP tracker package
// Shared types, sizes and codes for the request/reply tracker.
// ----------------------------------------------------------------------------
package arpt_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAXP_W      = 5;
    localparam int TMO_W       = 16;
    localparam int CMP_W       = (CNT_W > MAXP_W) ? CNT_W : MAXP_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [31:0]           stamp_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam logic [15:0] ARP_OP_REQUEST  = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY    = 16'd2;
    localparam logic [15:0] ARP_OP_RREQUEST = 16'd3;
    localparam logic [15:0] ARP_OP_RREPLY   = 16'd4;

    localparam cfg_idx_t CFG_MAX_PENDING   = 2'd0;
    localparam cfg_idx_t CFG_TIMEOUT_TICKS = 2'd1;
    localparam cfg_idx_t CFG_ANNOUNCE      = 2'd2;

    localparam logic [MAXP_W-1:0] MAXP_RESET = 5'd16;
    localparam logic [TMO_W-1:0]  TMO_RESET  = 16'd1000;

    typedef enum logic [3:0] {
        EV_QUEUED   = 4'd0,
        EV_OVERFLOW = 4'd1,
        EV_MATCH    = 4'd2,
        EV_LATE     = 4'd3,
        EV_ORPHAN   = 4'd4,
        EV_ANNOUNCE = 4'd5,
        EV_EXPIRED  = 4'd6,
        EV_RARP     = 4'd7,
        EV_UNKNOWN  = 4'd8
    } event_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] arp_op;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } in_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [47:0] alert_mac;
        logic [31:0] alert_sender_ip;
        logic [31:0] alert_target_ip;
        logic        last;
    } out_t;

    // one pending request
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] sip;
        logic [31:0] tip;
        stamp_t      stamp;
    } entry_t;

    // command to the shared compare unit
    typedef struct packed {
        logic             age_mode;
        logic             y_is_req;
        logic [31:0]      y_sip;
        logic [31:0]      y_tip;
        stamp_t           now;
        logic [TMO_W-1:0] timeout;
    } cmp_req_t;

endpackage

// ===== hdl/arpt_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// ARP tracker compare unit
// Shared unit: either reply-to-request pairing or request age check.
// ----------------------------------------------------------------------------
module arpt_cmp_unit (
    input  arpt_pkg::cmp_req_t req,
    input  arpt_pkg::entry_t   ent,
    output logic               hit
);

    arpt_pkg::stamp_t age;
    logic             pair_hit;

    assign age      = req.now - ent.stamp;
    assign pair_hit = (ent.tip == req.y_sip) &&
                      ((ent.sip == req.y_tip) || ((req.y_tip == req.y_sip) && req.y_is_req));
    assign hit      = req.age_mode ? (age > arpt_pkg::stamp_t'(req.timeout)) : pair_hit;

endmodule

// ===== hdl/arp_request_reply_tracker_core.sv =====
// Flow: a request, RARP or other packet passes decode and then emit, which loads the
// result; a reply passes decode, a check of the newest entry, a scan of the older
// entries from the oldest, then emit. An announcement matched as a reply goes on as one.
// A tick runs the age check and gives no result when nothing expires; else each alert
// passes age check, peek and emit. One item at a time: in_ready returns the cycle after
// the final result is loaded, and an output stall holds the tracker in emit.
// ----------------------------------------------------------------------------
// ARP request/reply tracker
// Queues ARP requests, matches replies, expires stale requests on ticks.
// Reset clears control state, counters and config; queue entries stay undefined.
// ----------------------------------------------------------------------------
`include "arp_request_reply_tracker_core_macros.svh"

module arp_request_reply_tracker_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  arpt_pkg::in_t        in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output arpt_pkg::out_t       out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  arpt_pkg::cfg_idx_t   cfg_index,
    input  arpt_pkg::cfg_data_t  cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_AGE    = 7'b0000100,
        S_PEEK   = 7'b0001000,
        S_NEWEST = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t                             state_reg, state_next;
    arpt_pkg::in_t                      item_reg;
    arpt_pkg::cnt_t                     cnt_reg;
    arpt_pkg::stamp_t                   tick_reg;
    logic [arpt_pkg::MAXP_W-1:0]        maxp_reg;
    logic [arpt_pkg::TMO_W-1:0]         tmo_reg;
    logic                               ann_reg;
    arpt_pkg::idx_t                     scan_idx_reg, scan_idx_next;
    arpt_pkg::cnt_t                     exp_n_reg, exp_n_next;
    arpt_pkg::out_t                     hold_reg, hold_next;
    logic                               out_valid_reg;
    arpt_pkg::out_t                     out_data_reg;
    arpt_pkg::entry_t                   entry_reg [arpt_pkg::QUEUE_DEPTH];

    logic               in_fire;
    logic               push_en;
    logic               drop_en;
    arpt_pkg::idx_t     drop_idx;
    arpt_pkg::idx_t     rd_idx;
    logic               age_mode;
    logic               out_load;
    logic               hit;
    logic               has_room;
    logic               can_expire;
    arpt_pkg::cnt_t     scan_plus1;
    arpt_pkg::out_t     pkt_res;
    arpt_pkg::cmp_req_t cmp_req;
    arpt_pkg::entry_t   rd_entry;
    arpt_pkg::entry_t   new_entry;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- shared compare unit ----------------
    assign rd_entry = entry_reg[rd_idx];

    assign cmp_req.age_mode = age_mode;
    assign cmp_req.y_is_req = (item_reg.arp_op == arpt_pkg::ARP_OP_REQUEST);
    assign cmp_req.y_sip    = item_reg.sender_ip;
    assign cmp_req.y_tip    = item_reg.target_ip;
    assign cmp_req.now      = tick_reg;
    assign cmp_req.timeout  = tmo_reg;

    arpt_cmp_unit u_cmp (
        .req (cmp_req),
        .ent (rd_entry),
        .hit (hit)
    );

    assign has_room   = (arpt_pkg::cmp_t'(cnt_reg) < arpt_pkg::cmp_t'(maxp_reg)) &&
                        (cnt_reg < arpt_pkg::cnt_t'(arpt_pkg::QUEUE_DEPTH));
    assign can_expire = (cnt_reg != '0) &&
                        (exp_n_reg < arpt_pkg::cnt_t'(arpt_pkg::QUEUE_DEPTH)) && hit;
    assign scan_plus1 = arpt_pkg::cnt_t'(scan_idx_reg) + arpt_pkg::cnt_t'(1);

    assign new_entry.mac   = item_reg.sender_mac;
    assign new_entry.sip   = item_reg.sender_ip;
    assign new_entry.tip   = item_reg.target_ip;
    assign new_entry.stamp = tick_reg;

    always_comb
    begin
        pkt_res.event_res       = arpt_pkg::EV_UNKNOWN;
        pkt_res.alert_mac       = item_reg.sender_mac;
        pkt_res.alert_sender_ip = item_reg.sender_ip;
        pkt_res.alert_target_ip = item_reg.target_ip;
        pkt_res.last            = 1'b1;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next    = state_reg;
        hold_next     = hold_reg;
        scan_idx_next = scan_idx_reg;
        exp_n_next    = exp_n_reg;
        push_en       = 1'b0;
        drop_en       = 1'b0;
        drop_idx      = '0;
        rd_idx        = '0;
        age_mode      = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    exp_n_next = '0;
                    state_next = in_data.opcode ? S_AGE : S_DECODE;
                end
            end
            S_DECODE:
            begin
                hold_next  = pkt_res;
                state_next = S_EMIT;
                priority if (item_reg.arp_op == arpt_pkg::ARP_OP_REQUEST)
                begin
                    if (item_reg.target_ip != item_reg.sender_ip)
                    begin
                        if (has_room)
                        begin
                            push_en             = 1'b1;
                            hold_next.event_res = arpt_pkg::EV_QUEUED;
                        end
                        else
                        begin
                            hold_next.event_res = arpt_pkg::EV_OVERFLOW;
                        end
                    end
                    else
                    begin
                        // self-request: announcement, optionally matched as a reply after
                        hold_next.event_res = arpt_pkg::EV_ANNOUNCE;
                        hold_next.last      = !ann_reg;
                    end
                end
                else if (item_reg.arp_op == arpt_pkg::ARP_OP_REPLY)
                begin
                    state_next = S_NEWEST;
                end
                else if (item_reg.arp_op == arpt_pkg::ARP_OP_RREQUEST ||
                         item_reg.arp_op == arpt_pkg::ARP_OP_RREPLY)
                begin
                    hold_next.event_res = arpt_pkg::EV_RARP;
                end
                else
                begin
                    hold_next.event_res = arpt_pkg::EV_UNKNOWN;
                end
            end
            S_NEWEST:
            begin
                rd_idx     = arpt_pkg::idx_t'(cnt_reg - arpt_pkg::cnt_t'(1));
                hold_next  = pkt_res;
                state_next = S_EMIT;
                if (cnt_reg == '0)
                begin
                    hold_next.event_res = arpt_pkg::EV_ORPHAN;
                end
                else if (hit)
                begin
                    drop_en             = 1'b1;
                    drop_idx            = rd_idx;
                    hold_next.event_res = arpt_pkg::EV_MATCH;
                end
                else
                begin
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_idx    = scan_idx_reg;
                hold_next = pkt_res;
                if (scan_plus1 < cnt_reg)
                begin
                    if (hit)
                    begin
                        drop_en             = 1'b1;
                        drop_idx            = scan_idx_reg;
                        hold_next.event_res = arpt_pkg::EV_LATE;
                        state_next          = S_EMIT;
                    end
                    else
                    begin
                        scan_idx_next = arpt_pkg::idx_t'(scan_plus1);
                    end
                end
                else
                begin
                    hold_next.event_res = arpt_pkg::EV_ORPHAN;
                    state_next          = S_EMIT;
                end
            end
            S_AGE:
            begin
                age_mode = 1'b1;
                if (can_expire)
                begin
                    hold_next.event_res       = arpt_pkg::EV_EXPIRED;
                    hold_next.alert_mac       = rd_entry.mac;
                    hold_next.alert_sender_ip = rd_entry.sip;
                    hold_next.alert_target_ip = rd_entry.tip;
                    hold_next.last            = 1'b0;
                    drop_en                   = 1'b1;
                    exp_n_next                = exp_n_reg + arpt_pkg::cnt_t'(1);
                    state_next                = S_PEEK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PEEK:
            begin
                // look at the new oldest entry to know whether this alert is the last
                age_mode       = 1'b1;
                hold_next.last = !can_expire;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    if (hold_reg.last)
                        state_next = S_IDLE;
                    else
                        state_next = item_reg.opcode ? S_AGE : S_NEWEST;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            maxp_reg      <= arpt_pkg::MAXP_RESET;
            tmo_reg       <= arpt_pkg::TMO_RESET;
            ann_reg       <= 1'b0;
            scan_idx_reg  <= '0;
            exp_n_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            exp_n_reg     <= exp_n_next;
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            if (in_fire && in_data.opcode)
                tick_reg <= tick_reg + 32'd1;
            if (push_en)
                cnt_reg <= cnt_reg + arpt_pkg::cnt_t'(1);
            else if (drop_en)
                cnt_reg <= cnt_reg - arpt_pkg::cnt_t'(1);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    arpt_pkg::CFG_MAX_PENDING:   maxp_reg <= cfg_data[arpt_pkg::MAXP_W-1:0];
                    arpt_pkg::CFG_TIMEOUT_TICKS: tmo_reg  <= cfg_data[arpt_pkg::TMO_W-1:0];
                    arpt_pkg::CFG_ANNOUNCE:      ann_reg  <= cfg_data[0];
                    default:                     ;
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_data;
        hold_reg <= hold_next;
        if (out_load)
            out_data_reg <= hold_reg;
    end

    // pending queue, oldest at index 0; a drop closes the gap by shifting down
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < arpt_pkg::QUEUE_DEPTH - 1; j++)
        begin
            if (drop_en && (arpt_pkg::idx_t'(j) >= drop_idx))
                entry_reg[j] <= entry_reg[j + 1];
        end
        if (push_en)
            entry_reg[arpt_pkg::idx_t'(cnt_reg)] <= new_entry;
    end

    // ---------------- assertions ----------------
    `ARPT_AST_NXT(a_busy_after_beat, in_fire, !in_ready,
                  "tracker took a new beat while busy")
    `ARPT_AST_IMP(a_push_has_room, push_en,
                  cnt_reg < arpt_pkg::cnt_t'(arpt_pkg::QUEUE_DEPTH),
                  "push into full queue")
    `ARPT_AST_IMP(a_drop_nonempty, drop_en, cnt_reg != '0 && !push_en,
                  "drop from empty queue or with push")
    `ARPT_AST_NXT(a_drop_count, drop_en, cnt_reg == $past(cnt_reg) - arpt_pkg::cnt_t'(1),
                  "queue count not decremented on drop")
    `ARPT_AST_IMP(a_scan_in_range, state_reg == S_SCAN,
                  arpt_pkg::cnt_t'(scan_idx_reg) < cnt_reg,
                  "scan index beyond pending count")
    `ARPT_AST_IMP(a_out_from_emit, $rose(out_valid_reg), $past(state_reg) == S_EMIT,
                  "result beat not issued by emit state")

endmodule
